[sv/pfh_pkg.sv]
`timescale 1ns / 1ps
package pfh_pkg;

  // Octave unit latency, from sample position in to octave value out.
  localparam int OCT_LAT = 17;

  localparam logic [31:0] HASH_MUL_B = 32'd77931942;
  localparam logic [31:0] HASH_MUL_A = 32'd2048419325;

  // ceil(2^28 / 25): exact quotient for x below about 14e6
  localparam logic [23:0] DIV25_MUL = 24'd10737419;

  typedef struct packed {
    logic [19:0] q;
    logic [4:0]  r;
  } div25_t;

  // Lattice index and Q16 fraction of one axis.
  typedef struct packed {
    logic [31:0] ipart;
    logic [15:0] frac;
  } axis_pos_t;

  function automatic div25_t div25(input logic [23:0] x);
    logic [47:0] prod;
    logic [23:0] back;
    div25_t      res;
    prod  = x * DIV25_MUL;
    res.q = prod[47:28];
    back  = 24'(res.q) * 24'd25;
    res.r = 5'(x - back);
    return res;
  endfunction

endpackage

[sv/perlin_fbm_height_sample.sv]
`timescale 1ns / 1ps
// Terrain height (0..40) of one world column from fractal 2D gradient noise.
// Each column_x/column_z transaction is offset by 1000000 and sampled over
// OCTAVES octaves at (c + 1000000) * 3 * 2^i / 200, weighted by 2^-i; each
// lattice corner takes a gradient angle from a hash seeded by noise_seed.
// The octave sum (Q4.16) is scaled by 1.2, clamped to +-1.0 and mapped to
// floor((v + 1) * 20). Fully pipelined: input register, 17-stage octave
// units running side by side, three sum/scale stages; one column per clock
// while in_ready is high. A two-entry output register keeps the input open
// while one result waits; in_ready drops only when both are full. The user
// must write noise_seed via the cfg channel only while idle (unchecked).
module perlin_fbm_height_sample #(
  parameter int OCTAVES    = 12,
  parameter int ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [20:0] column_x,
  input  logic signed [20:0] column_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         height,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_noise_seed
);
  import pfh_pkg::*;

  localparam int LAT = 1 + OCT_LAT + 3;   // total pipeline depth
  localparam int NG  = (OCTAVES + 3) / 4; // groups of four octave terms

  logic [31:0]        seed;
  logic               en;
  logic [LAT-1:0]     vpipe;
  logic signed [21:0] px, pz;
  logic signed [19:0] oct_v [OCTAVES];
  logic signed [21:0] grp_c [NG];
  logic signed [21:0] grp   [NG];
  logic signed [21:0] tot;
  logic signed [19:0] sum_sat;
  logic [23:0]        m;
  logic [47:0]        mprod;
  logic [21:0]        q5;
  logic signed [22:0] vs, vc;
  logic [22:0]        hprod;
  logic [5:0]         h_new;
  logic               skid_valid;
  logic [5:0]         skid_height;
  logic               push, take;

  // Seed register; user must send config writes only while idle (unchecked).
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid) begin
      seed <= cfg_noise_seed;
    end
  end

  // Whole pipeline advances unless the skid entry is occupied.
  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // Input stage: offset world coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      px <= 22'(column_x) + 22'sd1000000;
      pz <= 22'(column_z) + 22'sd1000000;
    end
  end

  for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
    pfh_octave #(.OCT_IDX(i), .ANGLE_BITS(ANGLE_BITS)) u_oct (
      .clk (clk),
      .en  (en),
      .seed(seed),
      .px  (px),
      .pz  (pz),
      .v   (oct_v[i])
    );
  end

  // Weighted octave terms, summed four at a time. Terms are bounded near
  // +-2^17, so the running sum never reaches the Q4.16 limits before the end.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_c[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (4 * g + j < OCTAVES) begin
          grp_c[g] = grp_c[g] + 22'(oct_v[4*g+j] >>> (4 * g + j));
        end
      end
    end
    tot = '0;
    for (int g = 0; g < NG; g++) begin
      tot = tot + grp[g];
    end
  end

  // floor(sum * 6 / 5): offset to positive, reciprocal multiply
  assign m     = 24'(24'(sum_sat) * 24'sd6 + 24'sd5242880);
  assign mprod = m * 48'd13421773;

  // Scale back, clamp to +-1.0, map to blocks.
  assign vs    = $signed({1'b0, q5}) - 23'sd1048576;
  assign vc    = (vs > 23'sd65536) ? 23'sd65536 :
                 (vs < -23'sd65536) ? -23'sd65536 : vs;
  assign hprod = 23'(vc + 23'sd65536) * 23'd20;
  assign h_new = hprod[21:16];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NG; g++) grp[g] <= grp_c[g];
      sum_sat <= (tot > 22'sd524287) ? 20'sd524287 :
                 (tot < -22'sd524288) ? -20'sd524288 : 20'(tot);
      q5      <= mprod[47:26];
    end
  end

  // Output register plus skid entry.
  assign push = en && vpipe[LAT-1];
  assign take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        height <= skid_height;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        height <= h_new;
      end else begin
        skid_height <= h_new;
      end
    end
  end

endmodule

[sv/pfh_split.sv]
`timescale 1ns / 1ps
module pfh_split #(
  parameter int OCT_IDX = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [21:0]  p,
  output pfh_pkg::axis_pos_t  pos
);
  import pfh_pkg::*;

  // n = 3p * 2^i ; cell = floor(n / 200) ; frac = floor((n mod 200) * 8192 / 25)
  logic [23:0]        p3u;
  div25_t             d1, d2, d3;
  logic signed [19:0] q0_1, q0_2;
  logic [4:0]         r0_1, w_2;
  logic [19:0]        u_2;
  logic signed [39:0] acc;
  logic [31:0]        cell_3;
  logic [7:0]         rem_3;

  assign p3u = 24'({{2{p[21]}}, p} * 24'd3 + 24'd204800);
  assign d1  = div25(p3u);
  assign d2  = div25(24'(r0_1) << OCT_IDX);
  assign acc = (40'(q0_2) <<< OCT_IDX) + 40'(u_2);
  assign d3  = div25(24'({rem_3, 13'b0}));

  always_ff @(posedge clk) begin
    if (en) begin
      q0_1      <= $signed(d1.q - 20'd8192);
      r0_1      <= d1.r;
      q0_2      <= q0_1;
      u_2       <= d2.q;
      w_2       <= d2.r;
      cell_3    <= acc[34:3];
      rem_3     <= 8'(acc[2:0]) * 8'd25 + 8'(w_2);
      pos.ipart <= cell_3;
      pos.frac  <= d3.q[15:0];
    end
  end

endmodule

[sv/pfh_qsin.sv]
`timescale 1ns / 1ps
module pfh_qsin (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        ph,
  output logic signed [15:0] g
);

  // quarter-wave polynomial t*(A - t^2*(B - t^2*C)), Q14 in, Q1.15 out
  logic [14:0] rr, rr1, rr2, rr3;
  logic [14:0] t2_1, t2_2;
  logic [14:0] inner2;
  logic [15:0] mid3;
  logic        neg1, neg2, neg3;
  logic [31:0] sq, p2, p3, p4;
  logic [14:0] res;

  assign rr  = ph[14] ? 15'(15'd16384 - 15'(ph[13:0])) : 15'(ph[13:0]);
  assign sq  = 32'(rr) * 32'(rr);
  assign p2  = 32'(t2_1) * 32'd2320;
  assign p3  = 32'(t2_2) * 32'(inner2);
  assign p4  = 32'(rr3) * 32'(mid3);
  assign res = (p4[31:14] > 18'd32767) ? 15'd32767 : p4[28:14];

  always_ff @(posedge clk) begin
    if (en) begin
      rr1    <= rr;
      t2_1   <= sq[28:14];
      neg1   <= ph[15];
      rr2    <= rr1;
      t2_2   <= t2_1;
      inner2 <= 15'(32'd21024 - (p2 >> 14));
      neg2   <= neg1;
      rr3    <= rr2;
      mid3   <= 16'(32'd51472 - (p3 >> 14));
      neg3   <= neg2;
      g      <= neg3 ? -$signed({1'b0, res}) : $signed({1'b0, res});
    end
  end

endmodule

[sv/pfh_corner.sv]
`timescale 1ns / 1ps
module pfh_corner #(
  parameter int ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        seed,
  input  logic [31:0]        cx,
  input  logic [31:0]        cz,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dz,
  output logic signed [18:0] dot
);
  import pfh_pkg::*;

  localparam int DLY = 7;  // hash (3) + sin/cos (4)

  logic [31:0]              a1, b1, a2, b2, a3;
  logic [ANGLE_BITS-1:0]    k;
  logic [15:0]              ph_s, ph_c;
  logic signed [15:0]       gs, gc;
  logic signed [16:0]       dx_d [DLY];
  logic signed [16:0]       dz_d [DLY];
  logic signed [32:0]       mx, mz;
  logic signed [33:0]       dsum;

  assign k    = a3[31 -: ANGLE_BITS];
  assign ph_s = 16'(k) << (16 - ANGLE_BITS);
  assign ph_c = ph_s + 16'h4000;
  assign dsum = 34'(mx) + 34'(mz);

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= cx * seed;
      b1 <= cz;
      a2 <= a1;
      b2 <= (b1 ^ {a1[15:0], a1[31:16]}) * HASH_MUL_B;
      a3 <= (a2 ^ {b2[15:0], b2[31:16]}) * HASH_MUL_A;
      dx_d[0] <= dx;
      dz_d[0] <= dz;
      for (int i = 1; i < DLY; i++) begin
        dx_d[i] <= dx_d[i-1];
        dz_d[i] <= dz_d[i-1];
      end
      mx  <= dx_d[DLY-1] * gs;
      mz  <= dz_d[DLY-1] * gc;
      dot <= 19'(dsum >>> 15);
    end
  end

  pfh_qsin u_sin (.clk(clk), .en(en), .ph(ph_s), .g(gs));
  pfh_qsin u_cos (.clk(clk), .en(en), .ph(ph_c), .g(gc));

endmodule

[sv/pfh_octave.sv]
`timescale 1ns / 1ps
module pfh_octave #(
  parameter int OCT_IDX    = 0,
  parameter int ANGLE_BITS = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        seed,
  input  logic signed [21:0] px,
  input  logic signed [21:0] pz,
  output logic signed [19:0] v
);
  import pfh_pkg::*;

  localparam int WX_DLY = 8;   // delays the x smoothstep weight to meet the corner dot products
  localparam int WZ_DLY = 10;  // delays the z weight to meet the x-blended values

  axis_pos_t          sx, sz;
  logic [31:0]        x1, z1;
  logic signed [16:0] dx0, dx1, dz0, dz1;
  logic signed [18:0] n00, n10, n01, n11;
  logic [15:0]        fx1, fz1;
  logic [15:0]        ssx, ssz;
  logic [31:0]        sqx, sqz;
  logic [33:0]        smx, smz;
  logic [16:0]        wx_d [WX_DLY];
  logic [16:0]        wz_d [WZ_DLY];
  logic signed [37:0] d0, d1;
  logic signed [18:0] n00_l, n01_l;
  logic signed [19:0] i0, i1, i0_l;
  logic signed [38:0] e;

  assign x1  = sx.ipart + 32'd1;
  assign z1  = sz.ipart + 32'd1;
  assign dx0 = $signed({1'b0, sx.frac});
  assign dx1 = $signed({1'b1, sx.frac});
  assign dz0 = $signed({1'b0, sz.frac});
  assign dz1 = $signed({1'b1, sz.frac});

  assign sqx = 32'(sx.frac) * 32'(sx.frac);
  assign sqz = 32'(sz.frac) * 32'(sz.frac);
  assign smx = 34'(ssx) * 34'(18'd196608 - {1'b0, fx1, 1'b0});
  assign smz = 34'(ssz) * 34'(18'd196608 - {1'b0, fz1, 1'b0});

  pfh_split #(.OCT_IDX(OCT_IDX)) u_sx (.clk(clk), .en(en), .p(px), .pos(sx));
  pfh_split #(.OCT_IDX(OCT_IDX)) u_sz (.clk(clk), .en(en), .p(pz), .pos(sz));

  pfh_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c00 (.clk(clk), .en(en), .seed(seed),
    .cx(sx.ipart), .cz(sz.ipart), .dx(dx0), .dz(dz0), .dot(n00));
  pfh_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c10 (.clk(clk), .en(en), .seed(seed),
    .cx(x1), .cz(sz.ipart), .dx(dx1), .dz(dz0), .dot(n10));
  pfh_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c01 (.clk(clk), .en(en), .seed(seed),
    .cx(sx.ipart), .cz(z1), .dx(dx0), .dz(dz1), .dot(n01));
  pfh_corner #(.ANGLE_BITS(ANGLE_BITS)) u_c11 (.clk(clk), .en(en), .seed(seed),
    .cx(x1), .cz(z1), .dx(dx1), .dz(dz1), .dot(n11));

  always_ff @(posedge clk) begin
    if (en) begin
      // smoothstep weights
      ssx <= sqx[31:16];
      ssz <= sqz[31:16];
      fx1 <= sx.frac;
      fz1 <= sz.frac;
      wx_d[0] <= smx[32:16];
      wz_d[0] <= smz[32:16];
      for (int i = 1; i < WX_DLY; i++) wx_d[i] <= wx_d[i-1];
      for (int i = 1; i < WZ_DLY; i++) wz_d[i] <= wz_d[i-1];
      // blend along x, then z
      d0    <= 38'(20'(n10) - 20'(n00)) * $signed({1'b0, wx_d[WX_DLY-1]});
      d1    <= 38'(20'(n11) - 20'(n01)) * $signed({1'b0, wx_d[WX_DLY-1]});
      n00_l <= n00;
      n01_l <= n01;
      i0    <= 20'(n00_l) + 20'(d0 >>> 16);
      i1    <= 20'(n01_l) + 20'(d1 >>> 16);
      e     <= 39'(i1 - i0) * $signed({1'b0, wz_d[WZ_DLY-1]});
      i0_l  <= i0;
      v     <= i0_l + 20'(e >>> 16);
    end
  end

endmodule
